FILE: rtl/vsps_pkg.sv
package vsps_pkg;

  // configuration register indexes
  typedef enum logic [3:0] {
    REG_FOCAL_LENGTH     = 4'd0,
    REG_OBJECT_DIAMETER  = 4'd1,
    REG_CENTER_U         = 4'd2,
    REG_CENTER_V         = 4'd3,
    REG_STEP_GAIN        = 4'd4,
    REG_DESIRED_U        = 4'd5,
    REG_DESIRED_V        = 4'd6,
    REG_DESIRED_DIAMETER = 4'd7
  } cfg_reg_e;

  // pipeline shape
  localparam int FrontStages = 6;
  localparam int DivQBits    = 48;
  localparam int DivSteps    = 2;
  localparam int DivStages   = DivQBits / DivSteps;
  localparam int BackStages  = 5;
  localparam int PipeStages  = FrontStages + DivStages + BackStages;

  // defaults after reset
  localparam logic [15:0] FocalLengthRst     = 16'd8000;
  localparam logic [15:0] ObjectDiameterRst  = 16'd6554;
  localparam logic [15:0] CenterURst         = 16'd3840;
  localparam logic [15:0] CenterVRst         = 16'd5120;
  localparam logic [15:0] StepGainRst        = 16'd85;
  localparam logic [15:0] DesiredURst        = 16'd3840;
  localparam logic [15:0] DesiredVRst        = 16'd5120;
  localparam logic [15:0] DesiredDiameterRst = 16'd1600;

  typedef struct packed {
    logic [15:0] focal_length;
    logic [15:0] object_diameter;
    logic [15:0] center_u;
    logic [15:0] center_v;
    logic [15:0] step_gain;
    logic [15:0] desired_u;
    logic [15:0] desired_v;
    logic [15:0] desired_diameter;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        circle_u;
    logic [15:0]        circle_v;
    logic [14:0]        circle_radius;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_word_t;

  typedef struct packed {
    logic               hold;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic               clipped;
  } out_word_t;

  // rotation matrix, row major, signed Q14 entries
  typedef logic [8:0][19:0] rot_t;

  // values that ride along with the division
  typedef struct packed {
    logic               hold;
    logic [2:0]         neg;
    logic [2:0]         ovf;
    logic [31:0]        den;
    rot_t               rot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } side_t;

  // divider word: remainder and shared dividend / quotient register per lane
  typedef struct packed {
    side_t                     side;
    logic [2:0][31:0]          rem;
    logic [2:0][DivQBits-1:0]  w;
  } div_pipe_t;

  // divide by 2^14, round half away from zero
  function automatic logic signed [63:0] rnd_q14(input logic signed [63:0] v);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + 64'd8192) >> 14;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

FILE: rtl/vsps_front.sv
module vsps_front (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  vsps_pkg::cfg_t       cfg_i,
  input  vsps_pkg::in_word_t   in_data_i,
  output vsps_pkg::div_pipe_t  out_o
);

  // stage a: feature errors, radius square, quaternion products
  logic signed [16:0] a_e0_q, a_e1_q, a_e2_q, a_uf_q, a_vf_q;
  logic [14:0]        a_r_q;
  logic [29:0]        a_rr_q;
  logic signed [31:0] a_xx_q, a_yy_q, a_zz_q, a_xy_q, a_xz_q, a_yz_q;
  logic signed [31:0] a_wx_q, a_wy_q, a_wz_q;
  logic               a_hold_q;
  logic signed [31:0] a_px_q, a_py_q, a_pz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_e0_q   <= {1'b0, cfg_i.desired_u} - {1'b0, in_data_i.circle_u};
      a_e1_q   <= {1'b0, cfg_i.desired_v} - {1'b0, in_data_i.circle_v};
      a_e2_q   <= {1'b0, cfg_i.desired_diameter} - {1'b0, in_data_i.circle_radius, 1'b0};
      a_uf_q   <= {1'b0, in_data_i.circle_u} - {1'b0, cfg_i.center_u};
      a_vf_q   <= {1'b0, in_data_i.circle_v} - {1'b0, cfg_i.center_v};
      a_r_q    <= in_data_i.circle_radius;
      a_rr_q   <= 30'(in_data_i.circle_radius) * 30'(in_data_i.circle_radius);
      a_xx_q   <= in_data_i.quat_x * in_data_i.quat_x;
      a_yy_q   <= in_data_i.quat_y * in_data_i.quat_y;
      a_zz_q   <= in_data_i.quat_z * in_data_i.quat_z;
      a_xy_q   <= in_data_i.quat_x * in_data_i.quat_y;
      a_xz_q   <= in_data_i.quat_x * in_data_i.quat_z;
      a_yz_q   <= in_data_i.quat_y * in_data_i.quat_z;
      a_wx_q   <= in_data_i.quat_w * in_data_i.quat_x;
      a_wy_q   <= in_data_i.quat_w * in_data_i.quat_y;
      a_wz_q   <= in_data_i.quat_w * in_data_i.quat_z;
      a_hold_q <= (in_data_i.circle_radius == 15'd0);
      a_px_q   <= in_data_i.pos_x;
      a_py_q   <= in_data_i.pos_y;
      a_pz_q   <= in_data_i.pos_z;
    end
  end

  // stage b: numerator products, denominator, rotation matrix in Q28
  logic signed [33:0] mq_d [9];
  logic signed [33:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  localparam logic signed [33:0] OneQ28 = 34'sd268435456;

  always_comb begin
    xx = 34'(a_xx_q);
    yy = 34'(a_yy_q);
    zz = 34'(a_zz_q);
    xy = 34'(a_xy_q);
    xz = 34'(a_xz_q);
    yz = 34'(a_yz_q);
    wx = 34'(a_wx_q);
    wy = 34'(a_wy_q);
    wz = 34'(a_wz_q);
    mq_d[0] = OneQ28 - ((yy + zz) <<< 1);
    mq_d[1] = (xy - wz) <<< 1;
    mq_d[2] = (xz + wy) <<< 1;
    mq_d[3] = (xy + wz) <<< 1;
    mq_d[4] = OneQ28 - ((xx + zz) <<< 1);
    mq_d[5] = (yz - wx) <<< 1;
    mq_d[6] = (xz - wy) <<< 1;
    mq_d[7] = (yz + wx) <<< 1;
    mq_d[8] = OneQ28 - ((xx + yy) <<< 1);
  end

  logic signed [33:0] b_pue_q, b_pve_q, b_pre0_q, b_pre1_q, b_n2_q;
  logic [31:0]        b_den_q;
  logic [30:0]        b_half_q;
  logic signed [33:0] b_mq_q [9];
  logic               b_hold_q;
  logic signed [31:0] b_px_q, b_py_q, b_pz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_pue_q  <= a_uf_q * a_e2_q;
      b_pve_q  <= a_vf_q * a_e2_q;
      b_pre0_q <= $signed({1'b0, a_r_q}) * a_e0_q;
      b_pre1_q <= $signed({1'b0, a_r_q}) * a_e1_q;
      b_n2_q   <= $signed({1'b0, cfg_i.focal_length}) * a_e2_q;
      b_den_q  <= {a_rr_q, 2'b00};
      b_half_q <= {a_rr_q, 1'b0};
      b_mq_q   <= mq_d;
      b_hold_q <= a_hold_q;
      b_px_q   <= a_px_q;
      b_py_q   <= a_py_q;
      b_pz_q   <= a_pz_q;
    end
  end

  // stage c: numerators, rotation matrix rounded to Q14
  logic signed [34:0] c_n_q [3];
  logic [19:0]        c_m_q [9];
  logic [31:0]        c_den_q;
  logic [30:0]        c_half_q;
  logic               c_hold_q;
  logic signed [31:0] c_px_q, c_py_q, c_pz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_n_q[0] <= 35'(b_pue_q) - (35'(b_pre0_q) <<< 1);
      c_n_q[1] <= 35'(b_pve_q) - (35'(b_pre1_q) <<< 1);
      c_n_q[2] <= 35'(b_n2_q);
      for (int i = 0; i < 9; i++) begin
        c_m_q[i] <= 20'(vsps_pkg::rnd_q14(64'(b_mq_q[i])));
      end
      c_den_q  <= b_den_q;
      c_half_q <= b_half_q;
      c_hold_q <= b_hold_q;
      c_px_q   <= b_px_q;
      c_py_q   <= b_py_q;
      c_pz_q   <= b_pz_q;
    end
  end

  // stage d: scale by the real diameter
  logic signed [51:0] d_pn_q [3];
  logic [19:0]        d_m_q [9];
  logic [31:0]        d_den_q;
  logic [30:0]        d_half_q;
  logic               d_hold_q;
  logic signed [31:0] d_px_q, d_py_q, d_pz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        d_pn_q[k] <= c_n_q[k] * $signed({1'b0, cfg_i.object_diameter});
      end
      d_m_q    <= c_m_q;
      d_den_q  <= c_den_q;
      d_half_q <= c_half_q;
      d_hold_q <= c_hold_q;
      d_px_q   <= c_px_q;
      d_py_q   <= c_py_q;
      d_pz_q   <= c_pz_q;
    end
  end

  // stage e: magnitude times 256 plus half the divisor
  logic [58:0]        x_d [3];
  logic [51:0]        mag;

  always_comb begin
    mag = '0;
    for (int k = 0; k < 3; k++) begin
      mag    = d_pn_q[k][51] ? 52'(-d_pn_q[k]) : 52'(d_pn_q[k]);
      x_d[k] = (59'(mag) << 8) + 59'(d_half_q);
    end
  end

  logic [58:0]        e_x_q [3];
  logic [2:0]         e_neg_q;
  logic [19:0]        e_m_q [9];
  logic [31:0]        e_den_q;
  logic               e_hold_q;
  logic signed [31:0] e_px_q, e_py_q, e_pz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_x_q    <= x_d;
      for (int k = 0; k < 3; k++) begin
        e_neg_q[k] <= d_pn_q[k][51];
      end
      e_m_q    <= d_m_q;
      e_den_q  <= d_den_q;
      e_hold_q <= d_hold_q;
      e_px_q   <= d_px_q;
      e_py_q   <= d_py_q;
      e_pz_q   <= d_pz_q;
    end
  end

  // stage f: quotient overflow check, divider start word
  vsps_pkg::div_pipe_t f_d, f_q;

  always_comb begin
    f_d            = '0;
    f_d.side.hold  = e_hold_q;
    f_d.side.neg   = e_neg_q;
    f_d.side.den   = e_den_q;
    f_d.side.pos_x = e_px_q;
    f_d.side.pos_y = e_py_q;
    f_d.side.pos_z = e_pz_q;
    for (int i = 0; i < 9; i++) begin
      f_d.side.rot[i] = e_m_q[i];
    end
    for (int k = 0; k < 3; k++) begin
      f_d.side.ovf[k] = 32'(e_x_q[k][58:48]) >= e_den_q;
      f_d.rem[k]      = 32'(e_x_q[k][58:48]);
      f_d.w[k]        = e_x_q[k][47:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q <= f_d;
    end
  end

  assign out_o = f_q;

endmodule

FILE: rtl/vsps_div_stage.sv
module vsps_div_stage (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  vsps_pkg::div_pipe_t  d_i,
  output vsps_pkg::div_pipe_t  d_o
);

  vsps_pkg::div_pipe_t d_d, d_q;
  logic [31:0]                   rem;
  logic [vsps_pkg::DivQBits-1:0] w;
  logic [32:0]                   t;
  logic                          qb;

  // restoring division, two quotient bits per stage on all three lanes
  always_comb begin
    d_d = d_i;
    rem = '0;
    w   = '0;
    t   = '0;
    qb  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      rem = d_i.rem[k];
      w   = d_i.w[k];
      for (int s = 0; s < vsps_pkg::DivSteps; s++) begin
        t = {rem, w[vsps_pkg::DivQBits-1]};
        if (t >= {1'b0, d_i.side.den}) begin
          rem = 32'(t - {1'b0, d_i.side.den});
          qb  = 1'b1;
        end else begin
          rem = t[31:0];
          qb  = 1'b0;
        end
        w = {w[vsps_pkg::DivQBits-2:0], qb};
      end
      d_d.rem[k] = rem;
      d_d.w[k]   = w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

FILE: rtl/vsps_back.sv
module vsps_back (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  vsps_pkg::cfg_t       cfg_i,
  input  vsps_pkg::div_pipe_t  d_i,
  output vsps_pkg::out_word_t  out_o
);

  localparam logic [47:0] ALim = 48'h8000_0000_0000;
  localparam logic [63:0] CLim = 64'h0000_0100_0000_0000;

  // stage g: clamp the quotient, times the step gain
  logic [47:0] g_mag_d [3];
  logic [2:0]  g_sat_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g_sat_d[k] = d_i.side.ovf[k] || (d_i.w[k] > ALim);
      g_mag_d[k] = g_sat_d[k] ? ALim : d_i.w[k];
    end
  end

  logic [63:0]          g_p_q [3];
  logic [2:0]           g_neg_q;
  logic                 g_clip_q;
  logic                 g_hold_q;
  vsps_pkg::rot_t       g_rot_q;
  logic signed [31:0]   g_px_q, g_py_q, g_pz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        g_p_q[k] <= 64'(g_mag_d[k]) * 64'(cfg_i.step_gain);
      end
      g_neg_q  <= d_i.side.neg;
      g_clip_q <= |g_sat_d;
      g_hold_q <= d_i.side.hold;
      g_rot_q  <= d_i.side.rot;
      g_px_q   <= d_i.side.pos_x;
      g_py_q   <= d_i.side.pos_y;
      g_pz_q   <= d_i.side.pos_z;
    end
  end

  // stage h: round to Q16.16, clamp, camera to effector axes
  logic [63:0]        cm;
  logic [2:0]         h_sat_d;
  logic signed [41:0] c_d [3];

  always_comb begin
    cm = '0;
    for (int k = 0; k < 3; k++) begin
      cm         = (g_p_q[k] + 64'd32768) >> 16;
      h_sat_d[k] = cm > CLim;
      if (h_sat_d[k]) begin
        cm = CLim;
      end
      c_d[k] = g_neg_q[k] ? -$signed(42'(cm)) : $signed(42'(cm));
    end
  end

  logic signed [41:0]   h_s_q [3];
  logic                 h_clip_q;
  logic                 h_hold_q;
  vsps_pkg::rot_t       h_rot_q;
  logic signed [31:0]   h_px_q, h_py_q, h_pz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_s_q[0] <= -c_d[1];
      h_s_q[1] <= c_d[0];
      h_s_q[2] <= c_d[2];
      h_clip_q <= g_clip_q | (|h_sat_d);
      h_hold_q <= g_hold_q;
      h_rot_q  <= g_rot_q;
      h_px_q   <= g_px_q;
      h_py_q   <= g_py_q;
      h_pz_q   <= g_pz_q;
    end
  end

  // stage i: rotation products
  logic signed [61:0]   i_p_q [9];
  logic                 i_clip_q;
  logic                 i_hold_q;
  logic signed [31:0]   i_px_q, i_py_q, i_pz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          i_p_q[i*3+j] <= $signed(h_rot_q[i*3+j]) * h_s_q[j];
        end
      end
      i_clip_q <= h_clip_q;
      i_hold_q <= h_hold_q;
      i_px_q   <= h_px_q;
      i_py_q   <= h_py_q;
      i_pz_q   <= h_pz_q;
    end
  end

  // stage j: row sums rounded back from Q14
  logic signed [63:0] acc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 64'(i_p_q[i*3]) + 64'(i_p_q[i*3+1]) + 64'(i_p_q[i*3+2]);
    end
  end

  logic signed [47:0]   j_step_q [3];
  logic                 j_clip_q;
  logic                 j_hold_q;
  logic signed [31:0]   j_pos_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        j_step_q[i] <= 48'(vsps_pkg::rnd_q14(acc[i]));
      end
      j_clip_q   <= i_clip_q;
      j_hold_q   <= i_hold_q;
      j_pos_q[0] <= i_px_q;
      j_pos_q[1] <= i_py_q;
      j_pos_q[2] <= i_pz_q;
    end
  end

  // stage k: add to position, saturate, hold bypass
  logic signed [48:0] t;
  logic signed [31:0] tgt [3];
  logic [2:0]         k_sat;

  always_comb begin
    t = '0;
    for (int i = 0; i < 3; i++) begin
      t        = 49'(j_pos_q[i]) + 49'(j_step_q[i]);
      k_sat[i] = 1'b0;
      tgt[i]   = t[31:0];
      if (t > 49'sd2147483647) begin
        tgt[i]   = 32'sh7fff_ffff;
        k_sat[i] = 1'b1;
      end else if (t < -49'sd2147483648) begin
        tgt[i]   = 32'sh8000_0000;
        k_sat[i] = 1'b1;
      end
    end
  end

  vsps_pkg::out_word_t k_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k_q.hold <= j_hold_q;
      if (j_hold_q) begin
        k_q.target_x <= j_pos_q[0];
        k_q.target_y <= j_pos_q[1];
        k_q.target_z <= j_pos_q[2];
        k_q.clipped  <= 1'b0;
      end else begin
        k_q.target_x <= tgt[0];
        k_q.target_y <= tgt[1];
        k_q.target_z <= tgt[2];
        k_q.clipped  <= j_clip_q | (|k_sat);
      end
    end
  end

  assign out_o = k_q;

endmodule

FILE: rtl/visual_servo_position_step.sv
// channel  | direction | handshake             | word
// ---------+-----------+-----------------------+----------------------------------
// in       | input     | in_valid_i/in_stall_o | in_data_i: circle and pose
// out      | output    | out_valid_o/out_stall_i | out_data_o: target and flags
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word per cycle while the pipeline is not stalled; results pass from the last stage through the output buffer.
// the depth is set by the 48-bit restoring divider, two quotient bits per stage.
// reset clears the valid bits, the output buffer and restores register defaults.
// a two-word output buffer takes results while out is stalled; the pipeline
// stops only when both entries are full and nothing is taken.
module visual_servo_position_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  vsps_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output vsps_pkg::out_word_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [3:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  localparam int Last = vsps_pkg::PipeStages - 1;

  // configuration registers
  vsps_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal_length     <= vsps_pkg::FocalLengthRst;
      cfg_q.object_diameter  <= vsps_pkg::ObjectDiameterRst;
      cfg_q.center_u         <= vsps_pkg::CenterURst;
      cfg_q.center_v         <= vsps_pkg::CenterVRst;
      cfg_q.step_gain        <= vsps_pkg::StepGainRst;
      cfg_q.desired_u        <= vsps_pkg::DesiredURst;
      cfg_q.desired_v        <= vsps_pkg::DesiredVRst;
      cfg_q.desired_diameter <= vsps_pkg::DesiredDiameterRst;
    end else if (cfg_valid_i) begin
      unique case (vsps_pkg::cfg_reg_e'(cfg_index_i))
        vsps_pkg::REG_FOCAL_LENGTH:     cfg_q.focal_length     <= cfg_data_i;
        vsps_pkg::REG_OBJECT_DIAMETER:  cfg_q.object_diameter  <= cfg_data_i;
        vsps_pkg::REG_CENTER_U:         cfg_q.center_u         <= cfg_data_i;
        vsps_pkg::REG_CENTER_V:         cfg_q.center_v         <= cfg_data_i;
        vsps_pkg::REG_STEP_GAIN:        cfg_q.step_gain        <= cfg_data_i;
        vsps_pkg::REG_DESIRED_U:        cfg_q.desired_u        <= cfg_data_i;
        vsps_pkg::REG_DESIRED_V:        cfg_q.desired_v        <= cfg_data_i;
        vsps_pkg::REG_DESIRED_DIAMETER: cfg_q.desired_diameter <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output buffer control and pipeline advance
  logic [1:0]          cnt_q;
  logic                en;
  logic                push;
  logic                pop;
  logic [Last:0]       v_q;
  vsps_pkg::out_word_t pipe_out;
  vsps_pkg::out_word_t head_q, tail_q;

  assign pop         = out_valid_o && !out_stall_i;
  assign en          = (cnt_q != 2'd2) || pop;
  assign push        = en && v_q[Last];
  assign in_stall_o  = !en;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = head_q;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Last-1:0], in_valid_i};
    end
  end

  // datapath
  vsps_pkg::div_pipe_t chain [vsps_pkg::DivStages+1];

  vsps_front u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .cfg_i     (cfg_q),
    .in_data_i (in_data_i),
    .out_o     (chain[0])
  );

  for (genvar g = 0; g < vsps_pkg::DivStages; g++) begin : g_div
    vsps_div_stage u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (chain[g]),
      .d_o   (chain[g+1])
    );
  end

  vsps_back u_back (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (cfg_q),
    .d_i   (chain[vsps_pkg::DivStages]),
    .out_o (pipe_out)
  );

  // two-entry output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case ({push, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          head_q <= pipe_out;
        end else begin
          tail_q <= pipe_out;
        end
      end
      2'b01: begin
        head_q <= tail_q;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          head_q <= pipe_out;
        end else begin
          head_q <= tail_q;
          tail_q <= pipe_out;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: verif/visual_servo_position_step_test.sv
module visual_servo_position_step_test;

  localparam int NumRandom = 1400;
  localparam int DrainCycles = vsps_pkg::PipeStages + 8;
  localparam int StallLimit = 5000;
  localparam int HoldOffCycles = 400;
  localparam logic [3:0] UnusedIndex = 4'hF;

  // target prediction and in-order comparison
  class servo_step_board;
    vsps_pkg::cfg_t regs;
    vsps_pkg::out_word_t pending_targets[$];
    int mismatches;

    function new();
      regs.focal_length = vsps_pkg::FocalLengthRst;
      regs.object_diameter = vsps_pkg::ObjectDiameterRst;
      regs.center_u = vsps_pkg::CenterURst;
      regs.center_v = vsps_pkg::CenterVRst;
      regs.step_gain = vsps_pkg::StepGainRst;
      regs.desired_u = vsps_pkg::DesiredURst;
      regs.desired_v = vsps_pkg::DesiredVRst;
      regs.desired_diameter = vsps_pkg::DesiredDiameterRst;
      mismatches = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] val);
      case (idx)
        vsps_pkg::REG_FOCAL_LENGTH: regs.focal_length = val;
        vsps_pkg::REG_OBJECT_DIAMETER: regs.object_diameter = val;
        vsps_pkg::REG_CENTER_U: regs.center_u = val;
        vsps_pkg::REG_CENTER_V: regs.center_v = val;
        vsps_pkg::REG_STEP_GAIN: regs.step_gain = val;
        vsps_pkg::REG_DESIRED_U: regs.desired_u = val;
        vsps_pkg::REG_DESIRED_V: regs.desired_v = val;
        vsps_pkg::REG_DESIRED_DIAMETER: regs.desired_diameter = val;
        default: ;
      endcase
    endfunction

    // divide, round half away from zero
    function longint rdiv(longint v, longint d);
      if (v >= 0) return (v + d / 2) / d;
      return -((-v + d / 2) / d);
    endfunction

    function longint limit(longint v, longint lim, inout bit flag);
      if (v > lim) begin
        flag = 1;
        return lim;
      end
      if (v < -lim) begin
        flag = 1;
        return -lim;
      end
      return v;
    endfunction

    function vsps_pkg::out_word_t next_target(vsps_pkg::in_word_t w);
      vsps_pkg::out_word_t o;
      longint r, e0, e1, e2, uf, vf, den, a, acc, t, qw, qx, qy, qz;
      longint n[3], c[3], s[3], pos[3], mq[3][3];
      bit clip;
      clip = 0;
      pos[0] = w.pos_x;
      pos[1] = w.pos_y;
      pos[2] = w.pos_z;
      o.hold = 0;
      o.clipped = 0;
      r = w.circle_radius;
      // zero radius passes the pose through
      if (r == 0) begin
        o.hold = 1;
        o.target_x = w.pos_x;
        o.target_y = w.pos_y;
        o.target_z = w.pos_z;
        return o;
      end
      // feature error through the inverse jacobian
      e0 = longint'(regs.desired_u) - longint'(w.circle_u);
      e1 = longint'(regs.desired_v) - longint'(w.circle_v);
      e2 = longint'(regs.desired_diameter) - 2 * r;
      uf = longint'(w.circle_u) - longint'(regs.center_u);
      vf = longint'(w.circle_v) - longint'(regs.center_v);
      den = 4 * r * r;
      n[0] = uf * e2 - 2 * r * e0;
      n[1] = vf * e2 - 2 * r * e1;
      n[2] = longint'(regs.focal_length) * e2;
      for (int k = 0; k < 3; k++) begin
        a = limit(rdiv(n[k] * longint'(regs.object_diameter) * 256, den), 64'sd1 <<< 47, clip);
        c[k] = limit(rdiv(a * longint'(regs.step_gain), 65536), 64'sd1 <<< 40, clip);
      end
      // camera to effector axes
      s[0] = -c[1];
      s[1] = c[0];
      s[2] = c[2];
      // rotation matrix in Q28
      qw = w.quat_w;
      qx = w.quat_x;
      qy = w.quat_y;
      qz = w.quat_z;
      mq[0][0] = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
      mq[0][1] = 2 * (qx * qy - qw * qz);
      mq[0][2] = 2 * (qx * qz + qw * qy);
      mq[1][0] = 2 * (qx * qy + qw * qz);
      mq[1][1] = (64'sd1 <<< 28) - 2 * (qx * qx + qz * qz);
      mq[1][2] = 2 * (qy * qz - qw * qx);
      mq[2][0] = 2 * (qx * qz - qw * qy);
      mq[2][1] = 2 * (qy * qz + qw * qx);
      mq[2][2] = (64'sd1 <<< 28) - 2 * (qx * qx + qy * qy);
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += rdiv(mq[i][j], 16384) * s[j];
        t = pos[i] + rdiv(acc, 16384);
        if (t > 64'sd2147483647) begin
          t = 64'sd2147483647;
          clip = 1;
        end
        if (t < -64'sd2147483648) begin
          t = -64'sd2147483648;
          clip = 1;
        end
        pos[i] = t;
      end
      o.target_x = pos[0][31:0];
      o.target_y = pos[1][31:0];
      o.target_z = pos[2][31:0];
      o.clipped = clip;
      return o;
    endfunction

    function void note_request(vsps_pkg::in_word_t w);
      pending_targets.push_back(next_target(w));
    endfunction

    function void check_target(vsps_pkg::out_word_t got);
      vsps_pkg::out_word_t exp_w;
      if (pending_targets.size() == 0) begin
        $error("unexpected word hold=%0d x=%0d", got.hold, got.target_x);
        mismatches++;
        return;
      end
      exp_w = pending_targets.pop_front();
      if (got.hold !== exp_w.hold) begin
        $error("hold: expected %0d got %0d", exp_w.hold, got.hold);
        mismatches++;
      end
      if (got.target_x !== exp_w.target_x) begin
        $error("target_x: expected %0d got %0d", exp_w.target_x, got.target_x);
        mismatches++;
      end
      if (got.target_y !== exp_w.target_y) begin
        $error("target_y: expected %0d got %0d", exp_w.target_y, got.target_y);
        mismatches++;
      end
      if (got.target_z !== exp_w.target_z) begin
        $error("target_z: expected %0d got %0d", exp_w.target_z, got.target_z);
        mismatches++;
      end
      if (got.clipped !== exp_w.clipped) begin
        $error("clipped: expected %0d got %0d", exp_w.clipped, got.clipped);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  vsps_pkg::in_word_t in_data;
  vsps_pkg::out_word_t out_data;
  logic [3:0] cfg_index;
  logic [15:0] cfg_data;

  servo_step_board board;
  int words_sent;
  int idle_cycles = 0;
  bit hold_off_done = 1'b0;

  visual_servo_position_step dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // output side: check each taken word, random stalls, one long hold-off and a stall-free stretch
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_stall = 1'b1;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) board.check_target(out_data);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (!hold_off_done && words_sent >= 500) begin
        hold_off_done = 1;
        hold_cnt = HoldOffCycles;
        out_stall <= 1'b1;
      end else if (words_sent >= 900 && words_sent < 1100) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_word(vsps_pkg::in_word_t w);
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    board.note_request(w);
    words_sent++;
    // random gaps, none in the middle stretch
    if (!(words_sent >= 700 && words_sent < 900) && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // valid stays high across back-to-back writes, dropped by the caller
  task automatic write_cfg(logic [3:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    board.write_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_targets.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic vsps_pkg::in_word_t random_word();
    vsps_pkg::in_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.circle_u = $urandom_range(65535);
    w.circle_v = $urandom_range(65535);
    if (pick < 5) w.circle_radius = 0;
    else if (pick < 60) w.circle_radius = $urandom_range(400, 1);
    else w.circle_radius = $urandom_range(32767);
    w.pos_x = (pick % 7 == 0) ? $urandom() : $signed($urandom_range(1 << 22)) - (1 << 21);
    w.pos_y = (pick % 5 == 0) ? $urandom() : $signed($urandom_range(1 << 22)) - (1 << 21);
    w.pos_z = (pick % 3 == 0) ? $urandom() : $signed($urandom_range(1 << 22)) - (1 << 21);
    w.quat_w = $signed($urandom_range(32768)) - 16384;
    w.quat_x = $signed($urandom_range(32768)) - 16384;
    w.quat_y = $signed($urandom_range(32768)) - 16384;
    w.quat_z = $signed($urandom_range(32768)) - 16384;
    return w;
  endfunction

  function automatic vsps_pkg::in_word_t make_word(logic [15:0] u, logic [15:0] v,
                                                   logic [14:0] r, logic signed [31:0] p,
                                                   logic signed [15:0] qw,
                                                   logic signed [15:0] qx,
                                                   logic signed [15:0] qy,
                                                   logic signed [15:0] qz);
    vsps_pkg::in_word_t w;
    w.circle_u = u;
    w.circle_v = v;
    w.circle_radius = r;
    w.pos_x = p;
    w.pos_y = -p;
    w.pos_z = p;
    w.quat_w = qw;
    w.quat_x = qx;
    w.quat_y = qy;
    w.quat_z = qz;
    return w;
  endfunction

  initial begin
    logic [15:0] setting;
    board = new();
    words_sent = 0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = vsps_pkg::REG_FOCAL_LENGTH;
    cfg_data = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at reset defaults
    send_word(make_word(3840, 5120, 800, 32'sd65536, 16384, 0, 0, 0));
    send_word(make_word(3840, 5120, 0, 32'sh7fffffff, 16384, 0, 0, 0));
    send_word(make_word(0, 0, 1, 32'sd0, 16384, 0, 0, 0));
    send_word(make_word(16'hffff, 16'hffff, 1, 32'sd0, 0, 16384, 0, 0));
    send_word(make_word(16'hffff, 0, 15'h7fff, 32'sh7fffffff, 0, 0, 16384, 0));
    send_word(make_word(0, 16'hffff, 15'h7fff, 32'sh80000000, 0, 0, 0, 16384));
    send_word(make_word(1000, 9000, 50, 32'sh7fff0000, -16384, -16384, -16384, -16384));
    send_word(make_word(1000, 9000, 50, 32'sh80010000, 16384, 16384, 16384, 16384));
    send_word(make_word(4000, 5000, 900, -32'sd123456, 11585, 0, 11585, 0));
    send_word(make_word(3000, 6000, 700, 32'sd999999, 8192, 8192, 8192, 8192));
    send_word(make_word(3840, 5120, 0, 32'sh80000000, -16384, 0, 0, 0));
    send_word(make_word(3840, 5121, 2, 32'sd1, 16384, 16384, 0, 0));
    send_word(make_word(12345, 54321, 16384, -32'sd1, 0, 0, 0, 0));
    drain();

    // phases with different register settings, extremes first
    for (int ph = 0; ph < 7; ph++) begin
      for (int k = 0; k < 8; k++) begin
        case (ph)
          0: setting = (k == vsps_pkg::REG_CENTER_U || k == vsps_pkg::REG_CENTER_V ||
                        k == vsps_pkg::REG_STEP_GAIN || k == vsps_pkg::REG_DESIRED_U ||
                        k == vsps_pkg::REG_DESIRED_V ||
                        k == vsps_pkg::REG_DESIRED_DIAMETER) ? 16'd0 : 16'd1;
          1: setting = 16'hffff;
          2: setting = $urandom_range(65535);
          default: setting = $urandom_range(65535);
        endcase
        write_cfg(vsps_pkg::cfg_reg_e'(k), setting);
      end
      write_cfg(UnusedIndex, $urandom_range(65535));
      cfg_valid <= 1'b0;
      for (int n = 0; n < NumRandom / 7; n++) send_word(random_word());
      drain();
    end

    if (board.mismatches == 0 && board.pending_targets.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
